### rtl/tritor_pkg.sv
package tritor_pkg;

  // Fixed port widths
  localparam int PHASE_W = 12;
  localparam int RES_W   = 16;

  // pi/2 in Q30
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  // Quarter-wave sine entry k, FB fraction bits, for a turn of 2^AB steps.
  // Odd Taylor series to the x^17 term in Q30, each term truncated,
  // then rounded half up and clamped to [0, 1.0].
  function automatic longint sine_entry(input int ab, input int fb, input int k);
    longint t;
    longint x2;
    longint term;
    longint sum;
    longint half;
    longint one;
    int     rsh;
    rsh  = 30 - fb;
    half = (rsh > 0) ? (longint'(1) <<< (rsh - 1)) : longint'(0);
    one  = longint'(1) <<< fb;
    t    = (HALF_PI_Q30 * longint'(k) + (longint'(1) <<< (ab - 3))) >>> (ab - 2);
    x2   = (t * t) >>> 30;
    term = t;
    sum  = t;
    term = ((term * x2) >>> 30) / 6;
    sum  = sum - term;
    term = ((term * x2) >>> 30) / 20;
    sum  = sum + term;
    term = ((term * x2) >>> 30) / 42;
    sum  = sum - term;
    term = ((term * x2) >>> 30) / 72;
    sum  = sum + term;
    term = ((term * x2) >>> 30) / 110;
    sum  = sum - term;
    term = ((term * x2) >>> 30) / 156;
    sum  = sum + term;
    term = ((term * x2) >>> 30) / 210;
    sum  = sum - term;
    term = ((term * x2) >>> 30) / 272;
    sum  = sum + term;
    if (sum < 0) begin
      sum = 0;
    end
    sum = (sum + half) >>> rsh;
    if (sum > one) begin
      sum = one;
    end
    if (k == 0) begin
      sum = 0;
    end
    if (k == (1 << (ab - 2))) begin
      sum = one;
    end
    return sum;
  endfunction

endpackage

### rtl/tritor_sin_rom.sv
// Quarter-wave sine table, two registered read ports
module tritor_sin_rom #(
  parameter int ANGLE_BITS = 12,
  parameter int FRAC_BITS  = 13
) (
  input  logic                 clk_i,
  input  logic [ANGLE_BITS-2:0] addr_a_i,
  input  logic [ANGLE_BITS-2:0] addr_b_i,
  output logic [FRAC_BITS:0]   data_a_o,
  output logic [FRAC_BITS:0]   data_b_o
);
  import tritor_pkg::*;

  localparam int QUARTER = 1 << (ANGLE_BITS - 2);

  typedef logic [FRAC_BITS:0] entry_t;
  typedef entry_t tab_t [QUARTER+1];

  function automatic tab_t build_tab();
    tab_t tab;
    for (int k = 0; k <= QUARTER; k++) begin
      tab[k] = entry_t'(sine_entry(ANGLE_BITS, FRAC_BITS, k));
    end
    return tab;
  endfunction

  localparam tab_t SINE_TAB = build_tab();

  entry_t data_a_q;
  entry_t data_b_q;

  // Registered reads
  always_ff @(posedge clk_i) begin
    data_a_q <= SINE_TAB[addr_a_i];
    data_b_q <= SINE_TAB[addr_b_i];
  end

  assign data_a_o = data_a_q;
  assign data_b_o = data_b_q;

endmodule

### rtl/triaxial_tritorus_point_eval_unit.sv
// Triaxial tritorus point evaluator. Each transfer of (u_phase_i, v_phase_i)
// yields the surface point and both partial derivative vectors, signed fixed
// point with FRAC_BITS fraction bits, on the result ports, marked by a
// one-cycle done_o. One pair may be started in every cycle: busy_o is never
// raised, and results are never held back, so the receiver must take each
// one in the cycle it is shown. The pipeline is made of the
// phase adders, the registered sine table reads (six dual-port table copies
// serve the twelve sine and cosine lookups), the operand forming, the nine
// multipliers and the rounding stage, one register stage each.
module triaxial_tritorus_point_eval_unit #(
  parameter int ANGLE_BITS = 12,
  parameter int FRAC_BITS  = 13
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic        [tritor_pkg::PHASE_W-1:0] u_phase_i,
  input  logic        [tritor_pkg::PHASE_W-1:0] v_phase_i,
  output logic                                done_o,
  output logic signed [tritor_pkg::RES_W-1:0]   pos_x_o,
  output logic signed [tritor_pkg::RES_W-1:0]   pos_y_o,
  output logic signed [tritor_pkg::RES_W-1:0]   pos_z_o,
  output logic signed [tritor_pkg::RES_W-1:0]   du_x_o,
  output logic signed [tritor_pkg::RES_W-1:0]   du_y_o,
  output logic signed [tritor_pkg::RES_W-1:0]   du_z_o,
  output logic signed [tritor_pkg::RES_W-1:0]   dv_x_o,
  output logic signed [tritor_pkg::RES_W-1:0]   dv_y_o,
  output logic signed [tritor_pkg::RES_W-1:0]   dv_z_o
);
  import tritor_pkg::*;

  localparam int AB      = ANGLE_BITS;
  localparam int AW      = AB - 1;
  localparam int FULL    = 1 << AB;
  localparam int QUARTER = 1 << (AB - 2);
  localparam int OPW     = FRAC_BITS + 3;
  localparam int PW      = 2 * OPW;
  localparam int N_LK    = 12;
  localparam int N_RES   = 9;

  localparam logic [AB-1:0] PH_THIRD      = AB'((2 * FULL + 3) / 6);
  localparam logic [AB-1:0] PH_TWO_THIRDS = AB'((4 * FULL + 3) / 6);
  localparam logic [AW-1:0] QUARTER_ADDR  = AW'(QUARTER);

  localparam logic signed [OPW-1:0] FX_ONE = {2'b00, 1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [PW:0] RND_HALF =
    {{(PW + 1 - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};

  // Lookup slots: phase (u, ua, ub, v, va, vb) is slot/2, odd slots are cosines
  localparam int LK_SU  = 0;
  localparam int LK_CU  = 1;
  localparam int LK_SUA = 2;
  localparam int LK_CUA = 3;
  localparam int LK_SUB = 4;
  localparam int LK_CUB = 5;
  localparam int LK_SV  = 6;
  localparam int LK_CV  = 7;
  localparam int LK_SVA = 8;
  localparam int LK_CVA = 9;
  localparam int LK_SVB = 10;
  localparam int LK_CVB = 11;

  typedef struct packed {
    logic          neg;
    logic [AW-1:0] addr;
  } lk_t;

  // Table address and sign for the sine (or cosine) of a phase
  function automatic lk_t lookup(input logic [AB-1:0] ph, input logic is_cos);
    lk_t           lk;
    logic [1:0]    quad;
    logic [AW-1:0] rem;
    quad    = ph[AB-1:AB-2] + {1'b0, is_cos};
    rem     = {1'b0, ph[AB-3:0]};
    lk.neg  = quad[1];
    lk.addr = quad[0] ? (QUARTER_ADDR - rem) : rem;
    return lk;
  endfunction

  // Stage A: wrapped phases and their offsets
  logic [AB-1:0] ph_q [6];
  logic          vld_a_q;
  logic [AB+PHASE_W-1:0] u_ext;
  logic [AB+PHASE_W-1:0] v_ext;
  logic [AB-1:0]         u_ph;
  logic [AB-1:0]         v_ph;

  assign u_ext = {{AB{1'b0}}, u_phase_i};
  assign v_ext = {{AB{1'b0}}, v_phase_i};
  assign u_ph  = u_ext[AB-1:0];
  assign v_ph  = v_ext[AB-1:0];

  always_ff @(posedge clk_i) begin
    ph_q[0] <= u_ph;
    ph_q[1] <= u_ph + PH_THIRD;
    ph_q[2] <= u_ph + PH_TWO_THIRDS;
    ph_q[3] <= v_ph;
    ph_q[4] <= v_ph + PH_THIRD;
    ph_q[5] <= v_ph + PH_TWO_THIRDS;
  end

  // Stage B: table reads, signs travel alongside
  lk_t              lk_d [N_LK];
  logic [N_LK-1:0]  neg_q;
  logic [FRAC_BITS:0] mag [N_LK];
  logic             vld_b_q;

  always_comb begin
    for (int i = 0; i < N_LK; i++) begin
      lk_d[i] = lookup(ph_q[i / 2], 1'((i % 2)));
    end
  end

  for (genvar g = 0; g < N_LK / 2; g++) begin : g_rom
    tritor_sin_rom #(
      .ANGLE_BITS(ANGLE_BITS),
      .FRAC_BITS (FRAC_BITS)
    ) u_rom (
      .clk_i   (clk_i),
      .addr_a_i(lk_d[2*g].addr),
      .addr_b_i(lk_d[2*g+1].addr),
      .data_a_o(mag[2*g]),
      .data_b_o(mag[2*g+1])
    );
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < N_LK; i++) begin
      neg_q[i] <= lk_d[i].neg;
    end
  end

  // Stage C: signed operands, 1 + cos and negated sines
  logic signed [OPW-1:0] sval [N_LK];
  logic signed [OPW-1:0] fval [N_LK];
  logic signed [OPW-1:0] nval [N_LK];
  logic signed [OPW-1:0] opa_q [N_RES];
  logic signed [OPW-1:0] opb_q [N_RES];
  logic                  vld_c_q;

  always_comb begin
    for (int i = 0; i < N_LK; i++) begin
      sval[i] = neg_q[i] ? -$signed({2'b00, mag[i]}) : $signed({2'b00, mag[i]});
      fval[i] = neg_q[i] ? (FX_ONE - $signed({2'b00, mag[i]}))
                         : (FX_ONE + $signed({2'b00, mag[i]}));
      nval[i] = neg_q[i] ? $signed({2'b00, mag[i]}) : -$signed({2'b00, mag[i]});
    end
  end

  always_ff @(posedge clk_i) begin
    opa_q[0] <= sval[LK_SUA];
    opb_q[0] <= fval[LK_CVA];
    opa_q[1] <= sval[LK_SUB];
    opb_q[1] <= fval[LK_CVB];
    opa_q[2] <= sval[LK_SU];
    opb_q[2] <= fval[LK_CV];
    opa_q[3] <= sval[LK_CUA];
    opb_q[3] <= fval[LK_CVA];
    opa_q[4] <= sval[LK_CUB];
    opb_q[4] <= fval[LK_CVB];
    opa_q[5] <= sval[LK_CU];
    opb_q[5] <= fval[LK_CV];
    opa_q[6] <= sval[LK_SUA];
    opb_q[6] <= nval[LK_SVA];
    opa_q[7] <= sval[LK_SUB];
    opb_q[7] <= nval[LK_SVB];
    opa_q[8] <= sval[LK_SU];
    opb_q[8] <= nval[LK_SV];
  end

  // Stage D: products
  logic signed [PW-1:0] prod_q [N_RES];
  logic                 vld_d_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < N_RES; i++) begin
      prod_q[i] <= PW'(opa_q[i]) * PW'(opb_q[i]);
    end
  end

  // Stage E: round to nearest, ties upward, keep the low result bits
  logic signed [PW:0]       rnd_sum [N_RES];
  logic signed [PW+RES_W:0] rnd_ext [N_RES];
  logic signed [PW+RES_W:0] rnd_shf [N_RES];
  logic signed [RES_W-1:0]  res_q   [N_RES];
  logic                     done_q;

  always_comb begin
    for (int i = 0; i < N_RES; i++) begin
      rnd_sum[i] = $signed({prod_q[i][PW-1], prod_q[i]}) + RND_HALF;
      rnd_ext[i] = $signed({{RES_W{rnd_sum[i][PW]}}, rnd_sum[i]});
      rnd_shf[i] = rnd_ext[i] >>> FRAC_BITS;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < N_RES; i++) begin
      res_q[i] <= rnd_shf[i][RES_W-1:0];
    end
  end

  // Valid bits along the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
      vld_d_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      vld_a_q <= start_i && !busy_o;
      vld_b_q <= vld_a_q;
      vld_c_q <= vld_b_q;
      vld_d_q <= vld_c_q;
      done_q  <= vld_d_q;
    end
  end

  assign busy_o  = 1'b0;
  assign done_o  = done_q;
  assign pos_x_o = res_q[0];
  assign pos_y_o = res_q[1];
  assign pos_z_o = res_q[2];
  assign du_x_o  = res_q[3];
  assign du_y_o  = res_q[4];
  assign du_z_o  = res_q[5];
  assign dv_x_o  = res_q[6];
  assign dv_y_o  = res_q[7];
  assign dv_z_o  = res_q[8];

endmodule

### sim/tritorus_surface_checker.sv
`timescale 1ns / 1ps

module tritorus_surface_checker #(
  parameter int ANGLE_BITS = 12,
  parameter int FRAC_BITS  = 13
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic                                  busy_i,
  input  logic        [tritor_pkg::PHASE_W-1:0] u_phase_i,
  input  logic        [tritor_pkg::PHASE_W-1:0] v_phase_i,
  input  logic                                  done_i,
  input  logic signed [tritor_pkg::RES_W-1:0]   pos_x_i,
  input  logic signed [tritor_pkg::RES_W-1:0]   pos_y_i,
  input  logic signed [tritor_pkg::RES_W-1:0]   pos_z_i,
  input  logic signed [tritor_pkg::RES_W-1:0]   du_x_i,
  input  logic signed [tritor_pkg::RES_W-1:0]   du_y_i,
  input  logic signed [tritor_pkg::RES_W-1:0]   du_z_i,
  input  logic signed [tritor_pkg::RES_W-1:0]   dv_x_i,
  input  logic signed [tritor_pkg::RES_W-1:0]   dv_y_i,
  input  logic signed [tritor_pkg::RES_W-1:0]   dv_z_i,
  output int                                    errors_o,
  output int                                    pending_o
);

  import tritor_pkg::*;

  localparam int unsigned PH_FULL       = 1 << ANGLE_BITS;
  localparam int unsigned PH_MASK       = PH_FULL - 1;
  localparam int unsigned PH_QUARTER    = PH_FULL >> 2;
  localparam int unsigned PH_THIRD      = (2 * PH_FULL + 3) / 6;
  localparam int unsigned PH_TWO_THIRDS = (4 * PH_FULL + 3) / 6;
  localparam longint      FX_ONE        = longint'(1) <<< FRAC_BITS;
  localparam int          N_FIELDS      = 9;
  localparam int          MAX_PRINTED   = 100;

  // Field order: pos x/y/z, du x/y/z, dv x/y/z
  typedef logic [N_FIELDS-1:0][RES_W-1:0] surface_bundle_t;

  typedef struct {
    logic [PHASE_W-1:0] u;
    logic [PHASE_W-1:0] v;
    surface_bundle_t    vals;
  } surface_expect_t;

  longint          sine_q [0:PH_QUARTER];
  surface_expect_t surface_q [$];
  surface_bundle_t seen;

  // Quarter-wave sine table, Q30 Taylor series rounded to FRAC_BITS
  function automatic void build_sine_table();
    longint t;
    longint x2;
    longint term;
    longint acc;
    longint half;
    int     rsh;
    int     k;
    int     n;
    rsh  = 30 - FRAC_BITS;
    half = (rsh > 0) ? (longint'(1) <<< (rsh - 1)) : longint'(0);
    for (k = 0; k <= int'(PH_QUARTER); k++) begin
      t    = (HALF_PI_Q30 * longint'(k) + longint'(PH_QUARTER / 2)) / longint'(PH_QUARTER);
      x2   = (t * t) >>> 30;
      term = t;
      acc  = t;
      for (n = 2; n <= 16; n += 2) begin
        term = ((term * x2) >>> 30) / longint'(n * (n + 1));
        acc  = (n % 4 == 2) ? acc - term : acc + term;
      end
      if (acc < 0) begin
        acc = 0;
      end
      acc = (acc + half) >>> rsh;
      if (acc > FX_ONE) begin
        acc = FX_ONE;
      end
      sine_q[k] = acc;
    end
    // ends of the quarter are exact
    sine_q[0]          = 0;
    sine_q[PH_QUARTER] = FX_ONE;
  endfunction

  function automatic longint phase_sin(int unsigned p);
    int unsigned quad;
    int unsigned rem;
    longint      mag;
    p    = p & PH_MASK;
    quad = p / PH_QUARTER;
    rem  = p % PH_QUARTER;
    mag  = quad[0] ? sine_q[PH_QUARTER - rem] : sine_q[rem];
    return quad[1] ? -mag : mag;
  endfunction

  function automatic longint phase_cos(int unsigned p);
    return phase_sin(p + PH_QUARTER);
  endfunction

  // Product of two Q values, optionally negated first, rounded half up
  function automatic logic [RES_W-1:0] mul_round(longint a, longint b, bit negate);
    longint p;
    p = a * b;
    if (negate) begin
      p = -p;
    end
    p = (p + (FX_ONE >>> 1)) >>> FRAC_BITS;
    return p[RES_W-1:0];
  endfunction

  function automatic surface_bundle_t predict_surface(logic [PHASE_W-1:0] u_in,
                                                      logic [PHASE_W-1:0] v_in);
    int unsigned     u;
    int unsigned     v;
    int unsigned     ua;
    int unsigned     ub;
    int unsigned     va;
    int unsigned     vb;
    longint          sin_u;
    longint          sin_ua;
    longint          sin_ub;
    longint          ring_a;
    longint          ring_b;
    longint          ring_z;
    surface_bundle_t r;
    u      = int'(u_in) & PH_MASK;
    v      = int'(v_in) & PH_MASK;
    ua     = (u + PH_THIRD) & PH_MASK;
    ub     = (u + PH_TWO_THIRDS) & PH_MASK;
    va     = (v + PH_THIRD) & PH_MASK;
    vb     = (v + PH_TWO_THIRDS) & PH_MASK;
    sin_u  = phase_sin(u);
    sin_ua = phase_sin(ua);
    sin_ub = phase_sin(ub);
    ring_a = FX_ONE + phase_cos(va);
    ring_b = FX_ONE + phase_cos(vb);
    ring_z = FX_ONE + phase_cos(v);
    r[0]   = mul_round(sin_ua, ring_a, 1'b0);
    r[1]   = mul_round(sin_ub, ring_b, 1'b0);
    r[2]   = mul_round(sin_u, ring_z, 1'b0);
    r[3]   = mul_round(phase_cos(ua), ring_a, 1'b0);
    r[4]   = mul_round(phase_cos(ub), ring_b, 1'b0);
    r[5]   = mul_round(phase_cos(u), ring_z, 1'b0);
    // v-derivative carries the minus sign on all three axes
    r[6]   = mul_round(sin_ua, phase_sin(va), 1'b1);
    r[7]   = mul_round(sin_ub, phase_sin(vb), 1'b1);
    r[8]   = mul_round(sin_u, phase_sin(v), 1'b1);
    return r;
  endfunction

  function automatic string field_name(int i);
    case (i)
      0:       return "pos_x";
      1:       return "pos_y";
      2:       return "pos_z";
      3:       return "du_x";
      4:       return "du_y";
      5:       return "du_z";
      6:       return "dv_x";
      7:       return "dv_y";
      default: return "dv_z";
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    if (errors_o < MAX_PRINTED) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
    errors_o = errors_o + 1;
  endtask

  initial begin
    errors_o  = 0;
    pending_o = 0;
    build_sine_table();
  end

  assign seen = {dv_z_i, dv_y_i, dv_x_i, du_z_i, du_y_i, du_x_i, pos_z_i, pos_y_i, pos_x_i};

  // Watch both channels at each edge: check results first, then log new transfers
  always @(posedge clk_i) begin
    surface_expect_t ex;
    if (rst_ni) begin
      if (done_i === 1'b1) begin
        if (surface_q.size() == 0) begin
          report_mismatch("result strobe with no transfer outstanding");
        end else begin
          ex = surface_q.pop_front();
          for (int i = 0; i < N_FIELDS; i++) begin
            if (seen[i] !== ex.vals[i]) begin
              report_mismatch($sformatf("%s u=%0d v=%0d: got %0d, expected %0d",
                                        field_name(i), ex.u, ex.v,
                                        $signed(seen[i]), $signed(ex.vals[i])));
            end
          end
        end
      end
      if (start_i === 1'b1 && busy_i === 1'b0) begin
        ex.u    = u_phase_i;
        ex.v    = v_phase_i;
        ex.vals = predict_surface(u_phase_i, v_phase_i);
        surface_q.push_back(ex);
      end
      // count for the stimulus, updated through a nonblocking assignment
      pending_o <= surface_q.size();
    end
  end

endmodule

### sim/triaxial_tritorus_point_eval_unit_tb.sv
`timescale 1ns / 1ps

module triaxial_tritorus_point_eval_unit_tb;

  import tritor_pkg::*;

  localparam int ANGLE_BITS = 12;
  localparam int FRAC_BITS  = 13;
  localparam int N_RANDOM   = 1550;
  localparam int TAIL_WAIT  = 20;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      start_i;
  logic                      busy_o;
  logic        [PHASE_W-1:0] u_phase_i;
  logic        [PHASE_W-1:0] v_phase_i;
  logic                      done_o;
  logic signed [RES_W-1:0]   pos_x_o;
  logic signed [RES_W-1:0]   pos_y_o;
  logic signed [RES_W-1:0]   pos_z_o;
  logic signed [RES_W-1:0]   du_x_o;
  logic signed [RES_W-1:0]   du_y_o;
  logic signed [RES_W-1:0]   du_z_o;
  logic signed [RES_W-1:0]   dv_x_o;
  logic signed [RES_W-1:0]   dv_y_o;
  logic signed [RES_W-1:0]   dv_z_o;
  int                        mismatches;
  int                        outstanding;

  always #6 clk_i = ~clk_i;

  triaxial_tritorus_point_eval_unit #(
    .ANGLE_BITS (ANGLE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .busy_o    (busy_o),
    .u_phase_i (u_phase_i),
    .v_phase_i (v_phase_i),
    .done_o    (done_o),
    .pos_x_o   (pos_x_o),
    .pos_y_o   (pos_y_o),
    .pos_z_o   (pos_z_o),
    .du_x_o    (du_x_o),
    .du_y_o    (du_y_o),
    .du_z_o    (du_z_o),
    .dv_x_o    (dv_x_o),
    .dv_y_o    (dv_y_o),
    .dv_z_o    (dv_z_o)
  );

  tritorus_surface_checker #(
    .ANGLE_BITS (ANGLE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .busy_i    (busy_o),
    .u_phase_i (u_phase_i),
    .v_phase_i (v_phase_i),
    .done_i    (done_o),
    .pos_x_i   (pos_x_o),
    .pos_y_i   (pos_y_o),
    .pos_z_i   (pos_z_o),
    .du_x_i    (du_x_o),
    .du_y_i    (du_y_o),
    .du_z_i    (du_z_o),
    .dv_x_i    (dv_x_o),
    .dv_y_i    (dv_y_o),
    .dv_z_i    (dv_z_o),
    .errors_o  (mismatches),
    .pending_o (outstanding)
  );

  // Present one angle pair and hold it until the transfer edge
  task automatic send_pair(int u, int v);
    start_i   <= 1'b1;
    u_phase_i <= PHASE_W'(u);
    v_phase_i <= PHASE_W'(v);
    do begin
      @(posedge clk_i);
    end while (busy_o !== 1'b0);
  endtask

  // Drop start for a number of cycles, with junk on the phase inputs
  task automatic idle_for(int cycles);
    if (cycles > 0) begin
      start_i   <= 1'b0;
      u_phase_i <= PHASE_W'($urandom);
      v_phase_i <= PHASE_W'($urandom);
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  initial begin
    int u;
    int v;
    int base;
    int pick;
    int gap;
    start_i   <= 1'b0;
    u_phase_i <= '0;
    v_phase_i <= '0;
    rst_ni    <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: range ends, quadrant edges, offsets that wrap onto 0 and pi
    send_pair(0, 0);
    send_pair(4095, 4095);
    send_pair(0, 4095);
    send_pair(4095, 0);
    send_pair(1024, 1024);
    send_pair(2048, 2048);
    send_pair(3072, 3072);
    send_pair(1023, 1025);
    send_pair(3071, 2049);
    send_pair(1365, 2731);
    send_pair(2731, 1365);
    send_pair(2730, 1364);
    send_pair(683, 683);
    send_pair(3413, 3413);
    send_pair(341, 2389);
    send_pair(12'hAAA, 12'h555);
    send_pair(12'h555, 12'hAAA);
    send_pair(1, 4094);
    send_pair(2047, 1);
    idle_for(2);

    // Hold off until the pipe has drained completely
    start_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);

    // Random: mostly uniform, some clustered on quadrant and offset edges, some with u at a range end
    for (int i = 0; i < N_RANDOM; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        u = $urandom_range(0, 4095);
        v = $urandom_range(0, 4095);
      end else if (pick < 9) begin
        case ($urandom_range(0, 7))
          0:       base = 0;
          1:       base = 1024;
          2:       base = 2048;
          3:       base = 3072;
          4:       base = 1365;
          5:       base = 2731;
          6:       base = 683;
          default: base = 3413;
        endcase
        u = (base + $urandom_range(0, 8) - 4) & 12'hFFF;
        v = ($urandom_range(0, 1) ? u : (4096 - base + $urandom_range(0, 8) - 4)) & 12'hFFF;
      end else begin
        u = $urandom_range(0, 1) ? 4095 : 0;
        v = $urandom_range(0, 4095);
      end
      send_pair(u, v);

      if (i == N_RANDOM / 2) begin
        start_i <= 1'b0;
        do @(posedge clk_i); while (outstanding != 0);
      end else if ((i % 250) >= 50) begin
        // outside the back-to-back stretches: mostly short gaps, a few long
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          gap = 0;
        end else if (pick < 90) begin
          gap = $urandom_range(1, 3);
        end else if (pick < 97) begin
          gap = $urandom_range(4, 12);
        end else begin
          gap = $urandom_range(20, 60);
        end
        idle_for(gap);
      end
    end
    start_i <= 1'b0;

    // Drain, then keep watching for any stray strobe before the verdict
    do @(posedge clk_i); while (outstanding != 0);
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

### sim.f
rtl/tritor_pkg.sv
rtl/tritor_sin_rom.sv
rtl/triaxial_tritorus_point_eval_unit.sv
sim/tritorus_surface_checker.sv
sim/triaxial_tritorus_point_eval_unit_tb.sv
